/* sv/cssa_pkg.sv */
`default_nettype none

package cssa_pkg;

   // store size and run limit
   localparam int CAPACITY    = 1024;
   localparam int MAX_RUN     = 64;
   localparam int ADDR_W      = $clog2(CAPACITY);

   // field widths
   localparam int MODE_W      = 2;
   localparam int LEN_W       = 7;
   localparam int SLOT_W      = 10;
   localparam int CNT_W       = 11;
   localparam int STATUS_W    = 2;
   localparam int CNT_MAX     = (2 ** CNT_W) - 1;

   // divider step counter
   localparam int DIV_CNT_W   = $clog2(CNT_W);

   // register port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SPC_RESET   = 64;

   typedef logic [0:0] reg_index_type;
   localparam reg_index_type REG_SLOTS_PER_CHUNK = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CONFLICT = 2'd1,
      STATUS_CAPACITY = 2'd2,
      STATUS_BAD      = 2'd3
   } status_type;

endpackage

`default_nettype wire

/* sv/cssa_ram.sv */
`default_nettype none

module cssa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/chunked_stack_slot_allocator.sv */
`default_nettype none

// Stack-style slot allocator over a bitmap of occupied slots grouped into chunks.
// Commands: pulse start with req_mode, req_run_length and req_slot_index while busy
// is low; the command is taken at that edge and busy rises. When it is done, the
// result is shown for exactly one cycle with rsp_strobe high, and busy drops in the
// cycle after. The receiver cannot hold results off.
// Steps per command:
//   allocate : an 11-step divider for the chunk offset, then the placement steps
//              (gap, align, fit), then one bitmap write per slot
//   free     : one bitmap write; if the freed slot was just below the top, the top
//              pointer walks down (read, check) past free slots to a used one or zero
//   clear    : slot_index up to CAPACITY - 1 (one bitmap entry per cycle)
//   rejected : a bad command skips to the result; a run past capacity ends at fit
// One command at a time: the next one can be taken in the cycle after the strobe.
// The chunk size register is on the csr_ APB port at byte address 0; write it only
// while busy is low.
// Reset: busy stays high while the bitmap is swept clear;
// top pointer, slot count and chunk count are zero, chunk size is 64.
module chunked_stack_slot_allocator (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [cssa_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [cssa_pkg::LEN_W-1:0]          req_run_length,
   input  wire logic [cssa_pkg::SLOT_W-1:0]         req_slot_index,

   output logic                                     rsp_strobe,
   output logic      [cssa_pkg::SLOT_W-1:0]         rsp_first_slot,
   output logic      [cssa_pkg::CNT_W-1:0]          rsp_top_index,
   output logic      [cssa_pkg::CNT_W-1:0]          rsp_used_slots,
   output logic      [cssa_pkg::CNT_W-1:0]          rsp_open_chunks,
   output logic      [cssa_pkg::STATUS_W-1:0]       rsp_status,

   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cssa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [cssa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [cssa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   localparam int CW     = cssa_pkg::CNT_W;
   localparam int BASE_W = cssa_pkg::CNT_W + 1;
   localparam int AW     = cssa_pkg::ADDR_W;
   localparam int LW     = cssa_pkg::LEN_W;
   localparam int SW     = cssa_pkg::SLOT_W;

   typedef enum logic [13:0] {
      ST_INIT      = 14'b00000000000001,
      ST_IDLE      = 14'b00000000000010,
      ST_DIV       = 14'b00000000000100,
      ST_GAP       = 14'b00000000001000,
      ST_ALIGN     = 14'b00000000010000,
      ST_FIT       = 14'b00000000100000,
      ST_MARK      = 14'b00000001000000,
      ST_MARK_END  = 14'b00000010000000,
      ST_FREE      = 14'b00000100000000,
      ST_WALK_RD   = 14'b00001000000000,
      ST_WALK_CHK  = 14'b00010000000000,
      ST_CLEAR     = 14'b00100000000000,
      ST_CLEAR_END = 14'b01000000000000,
      ST_DONE      = 14'b10000000000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    spc_ff, spc_in;
   logic [CW-1:0]                    stack_top_ff, stack_top_in;
   logic [CW-1:0]                    used_ff, used_in;
   logic [CW-1:0]                    chunk_ff, chunk_in;
   logic [CW-1:0]                    ptr_ff, ptr_in;
   logic                             chk_ff, chk_in;

   logic [LW-1:0]                    len_ff, len_in;
   logic [SW-1:0]                    idx_ff, idx_in;
   logic [CW-1:0]                    s_ff, s_in;
   logic [CW-1:0]                    rem_ff, rem_in;
   logic [CW-1:0]                    quo_ff, quo_in;
   logic [cssa_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [BASE_W-1:0]                base_ff, base_in;
   logic [CW-1:0]                    end_ff, end_in;
   logic [SW-1:0]                    first_ff, first_in;
   cssa_pkg::status_type             status_ff, status_in;
   logic                             conflict_ff, conflict_in;

   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic                             ram_wdata;
   logic [AW-1:0]                    ram_raddr;
   logic                             ram_rdata;

   logic [CW-1:0]                    eff_size;
   logic                             len_bad;
   logic                             idx_bad;
   logic [CW-1:0]                    div_shift;
   logic [BASE_W-1:0]                div_diff;
   logic [BASE_W-1:0]                fit_end;
   logic [BASE_W-1:0]                used_sum;
   logic [CW-1:0]                    used_dec;
   logic [CW-1:0]                    top_m1;
   logic                             rd_hit;
   logic                             csr_wr;

   cssa_ram #(
      .WIDTH (1),
      .DEPTH (cssa_pkg::CAPACITY)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // chunk size as used: 0 acts as 1, above capacity acts as capacity
   always_comb begin
      if (spc_ff == '0) begin
         eff_size = CW'(1);
      end else if (spc_ff > CW'(cssa_pkg::CAPACITY)) begin
         eff_size = CW'(cssa_pkg::CAPACITY);
      end else begin
         eff_size = spc_ff;
      end
   end

   assign len_bad  = (req_run_length == '0) ||
                     (req_run_length > LW'(cssa_pkg::MAX_RUN)) ||
                     (CW'(req_run_length) > eff_size);
   assign idx_bad  = ({1'b0, req_slot_index} >= CW'(cssa_pkg::CAPACITY));

   // restoring divider step, remainder stays below the divisor
   assign div_shift = {rem_ff[CW-2:0], quo_ff[CW-1]};
   assign div_diff  = {1'b0, div_shift} - {1'b0, s_ff};

   assign fit_end  = base_ff + BASE_W'(len_ff);
   assign used_sum = {1'b0, used_ff} + BASE_W'(len_ff);
   assign used_dec = (used_ff != '0) ? used_ff - CW'(1) : used_ff;
   assign top_m1   = stack_top_ff - CW'(1);
   assign rd_hit   = chk_ff & ram_rdata;

   assign csr_wr   = csr_psel & csr_penable & csr_pwrite & csr_pready &
                     (csr_paddr[2] == cssa_pkg::REG_SLOTS_PER_CHUNK);

   always_comb begin
      state_in     = state_ff;
      spc_in       = spc_ff;
      stack_top_in = stack_top_ff;
      used_in      = used_ff;
      chunk_in     = chunk_ff;
      ptr_in       = ptr_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      s_in         = s_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      base_in      = base_ff;
      end_in       = end_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      conflict_in  = conflict_ff;
      chk_in       = (state_ff == ST_MARK) || (state_ff == ST_CLEAR);

      ram_we       = 1'b0;
      ram_waddr    = ptr_ff[AW-1:0];
      ram_wdata    = 1'b0;
      ram_raddr    = ptr_ff[AW-1:0];

      if (csr_wr) begin
         spc_in = csr_pwdata[CW-1:0];
      end

      unique case (state_ff)
         ST_INIT: begin
            ram_we = 1'b1;
            if (ptr_ff[AW-1:0] == AW'(cssa_pkg::CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               first_in    = '0;
               status_in   = cssa_pkg::STATUS_OK;
               conflict_in = 1'b0;
               len_in      = req_run_length;
               idx_in      = req_slot_index;
               case (req_mode)
                  cssa_pkg::MODE_ALLOC: begin
                     if (len_bad) begin
                        status_in = cssa_pkg::STATUS_BAD;
                        state_in  = ST_DONE;
                     end else begin
                        s_in       = eff_size;
                        rem_in     = '0;
                        quo_in     = stack_top_ff;
                        div_cnt_in = cssa_pkg::DIV_CNT_W'(CW - 1);
                        state_in   = ST_DIV;
                     end
                  end
                  cssa_pkg::MODE_FREE: begin
                     if (idx_bad) begin
                        status_in = cssa_pkg::STATUS_BAD;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_FREE;
                     end
                  end
                  cssa_pkg::MODE_CLEAR: begin
                     if (idx_bad) begin
                        status_in = cssa_pkg::STATUS_BAD;
                        state_in  = ST_DONE;
                     end else begin
                        ptr_in   = {1'b0, req_slot_index};
                        state_in = ST_CLEAR;
                     end
                  end
                  default: begin
                     status_in = cssa_pkg::STATUS_BAD;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end

         // quotient = chunk of the top, remainder = offset within it
         ST_DIV: begin
            if (!div_diff[BASE_W-1]) begin
               rem_in = div_diff[CW-1:0];
               quo_in = {quo_ff[CW-2:0], 1'b1};
            end else begin
               rem_in = div_shift;
               quo_in = {quo_ff[CW-2:0], 1'b0};
            end
            if (div_cnt_ff == '0) begin
               state_in = ST_GAP;
            end else begin
               div_cnt_in = div_cnt_ff - cssa_pkg::DIV_CNT_W'(1);
            end
         end

         // room left in the current chunk
         ST_GAP: begin
            rem_in   = s_ff - rem_ff;
            state_in = ST_ALIGN;
         end

         ST_ALIGN: begin
            if (CW'(len_ff) > rem_ff) begin
               base_in = {1'b0, stack_top_ff} + {1'b0, rem_ff};
               quo_in  = quo_ff + CW'(1);
            end else begin
               base_in = {1'b0, stack_top_ff};
            end
            state_in = ST_FIT;
         end

         ST_FIT: begin
            if (fit_end > BASE_W'(cssa_pkg::CAPACITY)) begin
               status_in = cssa_pkg::STATUS_CAPACITY;
               state_in  = ST_DONE;
            end else begin
               if (quo_ff >= chunk_ff) begin
                  chunk_in = quo_ff + CW'(1);
               end
               ptr_in   = base_ff[CW-1:0];
               end_in   = fit_end[CW-1:0];
               first_in = base_ff[SW-1:0];
               state_in = ST_MARK;
            end
         end

         // read-before-write: old bit comes back next cycle
         ST_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
            if (rd_hit) begin
               conflict_in = 1'b1;
            end
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff + CW'(1) == end_ff) begin
               state_in = ST_MARK_END;
            end
         end

         ST_MARK_END: begin
            stack_top_in = end_ff;
            used_in      = (used_sum > BASE_W'(cssa_pkg::CNT_MAX)) ?
                           CW'(cssa_pkg::CNT_MAX) : used_sum[CW-1:0];
            status_in    = (conflict_ff || rd_hit) ? cssa_pkg::STATUS_CONFLICT :
                                                     cssa_pkg::STATUS_OK;
            state_in     = ST_DONE;
         end

         ST_FREE: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            used_in   = used_dec;
            if ((stack_top_ff != '0) && ({1'b0, idx_ff} + CW'(1) == stack_top_ff)) begin
               stack_top_in = {1'b0, idx_ff};
               state_in     = ST_WALK_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_WALK_RD: begin
            ram_raddr = top_m1[AW-1:0];
            if (stack_top_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK_CHK;
            end
         end

         ST_WALK_CHK: begin
            if (!ram_rdata) begin
               stack_top_in = top_m1;
               state_in     = ST_WALK_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_CLEAR: begin
            ram_we = 1'b1;
            if (rd_hit) begin
               used_in = used_dec;
            end
            if (ptr_ff[AW-1:0] == AW'(cssa_pkg::CAPACITY - 1)) begin
               state_in = ST_CLEAR_END;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end

         ST_CLEAR_END: begin
            if (rd_hit) begin
               used_in = used_dec;
            end
            stack_top_in = {1'b0, idx_ff};
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_INIT;
            ptr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         spc_ff       <= CW'(cssa_pkg::SPC_RESET);
         stack_top_ff <= '0;
         used_ff      <= '0;
         chunk_ff     <= '0;
         ptr_ff       <= '0;
         chk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spc_ff       <= spc_in;
         stack_top_ff <= stack_top_in;
         used_ff      <= used_in;
         chunk_ff     <= chunk_in;
         ptr_ff       <= ptr_in;
         chk_ff       <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      s_ff        <= s_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      base_ff     <= base_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      status_ff   <= status_in;
      conflict_ff <= conflict_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_DONE);
   assign rsp_first_slot  = first_ff;
   assign rsp_top_index   = stack_top_ff;
   assign rsp_used_slots  = used_ff;
   assign rsp_open_chunks = chunk_ff;
   assign rsp_status      = status_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == cssa_pkg::REG_SLOTS_PER_CHUNK) ?
                       cssa_pkg::CSR_DATA_W'(spc_ff) : '0;

endmodule

`default_nettype wire

/* sv/cssa_checker.sv */
`default_nettype none

module cssa_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_strobe,
   input wire logic [cssa_pkg::SLOT_W-1:0]         rsp_first_slot,
   input wire logic [cssa_pkg::CNT_W-1:0]          rsp_top_index,
   input wire logic [cssa_pkg::STATUS_W-1:0]       rsp_status
);

   // bitmap sweep after reset keeps the block busy
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_reject_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_status == cssa_pkg::STATUS_CAPACITY) ||
                      (rsp_status == cssa_pkg::STATUS_BAD)))
      |-> ((rsp_first_slot == '0) &&
           (rsp_top_index <= cssa_pkg::CNT_W'(cssa_pkg::CAPACITY))))
      else $error("rejected beat carries a slot index");

endmodule

bind chunked_stack_slot_allocator cssa_checker u_cssa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_first_slot (rsp_first_slot),
   .rsp_top_index  (rsp_top_index),
   .rsp_status     (rsp_status)
);

`default_nettype wire
